@@ sv/lpcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcc_pkg
// shared types, codes and helpers of the log pattern count and capture block
// ----------------------------------------------------------------------------
package lpcc_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int VALUE_DEPTH_DEF = 32;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int LEN_W = 6;
	localparam int COUNT_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_C = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_D = 3'd5;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 14'd9999;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	typedef enum logic [1:0] {
		KIND_COUNT = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_EMPTY = 2'd2
	} result_kind_t;

	// job report handed from the scanner to the readout engine
	typedef struct packed {
		result_kind_t kind;
		logic [COUNT_W-1:0] count;
		logic ovf;
		logic trunc;
		logic [LEN_W-1:0] len;
		logic bank;
	} report_t;

	function automatic logic [7:0] pat_byte(input logic [255:0] pat, input logic [4:0] k);
		pat_byte = pat[{k, 3'b000} +: 8];
	endfunction

endpackage

@@ sv/lpcc_cell.sv @@
// ----------------------------------------------------------------------------
// lpcc_cell
// one window cell: compares its incoming byte with its pattern byte, then
// holds that byte for the next cell
// ----------------------------------------------------------------------------
module lpcc_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       clr,
	input  logic [7:0] byte_in,
	input  logic       vld_in,
	input  logic [7:0] pat,
	input  logic       en,
	output logic [7:0] byte_q,
	output logic       vld_q,
	output logic       eq
);

	// cells beyond the pattern length always agree
	assign eq = !en || (vld_in && (byte_in == pat));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in && !clr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_in;
		end
	end

endmodule

@@ sv/lpcc_ram.sv @@
// ----------------------------------------------------------------------------
// lpcc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lpcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/lpcc_readout.sv @@
// ----------------------------------------------------------------------------
// lpcc_readout
// turns a job report into result transactions, reading captured bytes from
// the value ram, with a read stage and an output register
// ----------------------------------------------------------------------------
module lpcc_readout #(
	parameter int IDX_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rep_load,
	input  lpcc_pkg::report_t           rep_in,
	output logic                        rep_free,
	output logic                        rd_en,
	output logic [IDX_W:0]              rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lpcc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);
	import lpcc_pkg::*;

	typedef struct packed {
		result_kind_t kind;
		logic [COUNT_W-1:0] count;
		logic ovf;
		logic trunc;
		logic last;
	} meta_t;

	report_t rep_q;
	logic rep_v_q;
	logic [LEN_W-1:0] rd_cnt_q;
	logic v_s1;
	meta_t meta_s1;
	logic o_v_q;
	meta_t meta_q;
	logic [7:0] byte_q;

	logic s1_mov, s1_free, issue, last_iss;

	assign s1_mov = v_s1 && (!o_v_q || m_tready);
	assign s1_free = !v_s1 || s1_mov;
	assign issue = rep_v_q && s1_free;
	assign last_iss = (rep_q.kind != KIND_VALUE) ||
		(({1'b0, rd_cnt_q} + (LEN_W+1)'(1)) == {1'b0, rep_q.len});
	assign rep_free = !rep_v_q || (issue && last_iss);

	assign rd_en = issue && (rep_q.kind == KIND_VALUE);
	assign rd_addr = {rep_q.bank, rd_cnt_q[IDX_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_v_q <= 1'b0;
			rd_cnt_q <= '0;
			v_s1 <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			if (rep_load) begin
				rep_v_q <= 1'b1;
				rd_cnt_q <= '0;
			end else if (issue && last_iss) begin
				rep_v_q <= 1'b0;
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + LEN_W'(1);
			end
			if (s1_free) begin
				v_s1 <= issue;
			end
			o_v_q <= s1_mov || (o_v_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (rep_load) begin
			rep_q <= rep_in;
		end
		if (issue) begin
			meta_s1 <= '{kind: rep_q.kind, count: rep_q.count, ovf: rep_q.ovf,
				trunc: rep_q.trunc, last: last_iss};
		end
		if (s1_mov) begin
			meta_q <= meta_s1;
			byte_q <= (meta_s1.kind == KIND_VALUE) ? rd_data : 8'd0;
		end
	end

	assign m_tvalid = o_v_q;
	assign m_tdata = {meta_q.trunc, byte_q, meta_q.ovf, meta_q.count};
	assign m_tuser = meta_q.kind;
	assign m_tlast = meta_q.last;

endmodule

@@ sv/log_pattern_count_and_capture.sv @@
// ----------------------------------------------------------------------------
// log_pattern_count_and_capture
// streaming log scanner: counts pattern matches or captures the text after
// the last match, reporting at the end of each job
// ----------------------------------------------------------------------------
// Log bytes stream in one per cycle, the main segment first and then the
// rotated one, and are matched against a pattern of up to MAX_PATTERN bytes
// by a row of window cells: each cell compares one window byte with its
// pattern byte and passes the byte on to its neighbor, so one byte is
// accepted every cycle. Matches never overlap within a segment; a zero byte
// stops matching for the rest of its segment. A count-mode job with any
// match ends in one result with the match count (held at 9999 with an
// overflow flag); a value-mode job with an accepted match ends in the
// bytes after the last one, one result transaction per byte, or one
// empty-value result. The first result passes the report, read and output
// registers; the rest follow one per cycle while m_tready holds. Captured
// text sits in a two-bank ram, so the next job fills one bank while the
// other drains; only a job-end byte waits, and only while the report of
// the previous job is still being read out. No clearing pass after reset.
// ----------------------------------------------------------------------------
module log_pattern_count_and_capture #(
	parameter int MAX_PATTERN = lpcc_pkg::MAX_PATTERN_DEF,
	parameter int VALUE_DEPTH = lpcc_pkg::VALUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [lpcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpcc_pkg::CFG_DATA_W-1:0]   cfg_data,
	// log byte stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lpcc_pkg::IN_TDATA_W-1:0]   s_tdata,  // data_byte, segment_end, zero pad
	input  logic                              s_tuser,  // segment
	input  logic                              s_tlast,  // job_end
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lpcc_pkg::OUT_TDATA_W-1:0]  m_tdata,  // match_count, count_overflow,
	                                                    // value_byte, value_truncated
	output logic [1:0]                        m_tuser,  // result_kind
	output logic                              m_tlast   // last_result
);
	import lpcc_pkg::*;

	// capture depth never goes past 32 bytes
	localparam int CAP = (VALUE_DEPTH < 32) ? VALUE_DEPTH : 32;
	localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

	// configuration registers
	logic mode_q;
	logic [5:0] plen_q;
	logic [255:0] pat_q;

	// per-segment and per-job state
	logic [4:0] holdoff_q;
	logic stopped_q;
	logic [COUNT_W-1:0] count_q;
	logic [LEN_W-1:0] len_q;
	logic capture_q;
	logic found_any_q;
	logic found_main_q;
	logic trunc_q;
	logic bank_q;

	// input fields
	logic [7:0] in_byte;
	logic in_seg, in_send, in_jend, in_acc;

	assign in_byte = s_tdata[7:0];
	assign in_send = s_tdata[8];
	assign in_seg = s_tuser;
	assign in_jend = s_tlast;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			plen_q <= 6'd1;
			pat_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q <= cfg_data[0];
				REG_PLEN:  plen_q <= cfg_data[5:0];
				REG_PAT_A: pat_q[63:0] <= cfg_data;
				REG_PAT_B: pat_q[127:64] <= cfg_data;
				REG_PAT_C: pat_q[191:128] <= cfg_data;
				REG_PAT_D: pat_q[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective pattern length, clamped to 1..MAX_PATTERN
	logic [5:0] n_eff;

	always_comb begin
		if (plen_q == 6'd0) begin
			n_eff = 6'd1;
		end else if (plen_q > 6'(MAX_PATTERN)) begin
			n_eff = 6'(MAX_PATTERN);
		end else begin
			n_eff = plen_q;
		end
	end

	// window cell row: cell i sees the byte i places back (cell 0 the new one)
	logic [7:0] win_byte [MAX_PATTERN];
	logic win_vld [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_eq;
	logic seg_reset;

	assign seg_reset = in_send || in_jend;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [7:0] c_in;
		logic c_vld;
		logic [4:0] c_k;

		if (i == 0) begin : g_head
			assign c_in = in_byte;
			assign c_vld = 1'b1;
		end else begin : g_link
			assign c_in = win_byte[i-1];
			assign c_vld = win_vld[i-1];
		end

		// the oldest byte of the window meets pattern byte 0
		assign c_k = 5'(n_eff - 6'(i) - 6'd1);

		lpcc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (in_acc),
			.clr     (seg_reset),
			.byte_in (c_in),
			.vld_in  (c_vld),
			.pat     (pat_byte(pat_q, c_k)),
			.en      (6'(i) < n_eff),
			.byte_q  (win_byte[i]),
			.vld_q   (win_vld[i]),
			.eq      (cell_eq[i])
		);
	end

	// match and capture decisions for the incoming byte
	logic stop_nx, hit, accepted, is_term, cap_store, cap_trunc;
	logic [LEN_W-1:0] len_nx;
	logic trunc_nx, found_any_nx;
	logic [COUNT_W-1:0] count_nx;

	assign stop_nx = stopped_q || (in_byte == CHAR_NUL);
	assign hit = (holdoff_q == 5'd0) && !stop_nx && (&cell_eq);
	// a rotated match only counts for capture while no main match was seen
	assign accepted = hit && (!in_seg || !found_main_q);
	assign is_term = (in_byte == CHAR_NEWLINE) || (in_byte == CHAR_NUL);
	assign cap_store = !accepted && capture_q && !is_term && (len_q < LEN_W'(CAP));
	assign cap_trunc = !accepted && capture_q && !is_term && (len_q >= LEN_W'(CAP));

	always_comb begin
		if (accepted) begin
			len_nx = '0;
		end else if (cap_store) begin
			len_nx = len_q + LEN_W'(1);
		end else begin
			len_nx = len_q;
		end
	end

	assign trunc_nx = accepted ? 1'b0 : (cap_trunc || trunc_q);
	assign found_any_nx = found_any_q || accepted;
	// running count sticks one above the limit
	assign count_nx = (hit && (count_q <= COUNT_LIMIT)) ? count_q + COUNT_W'(1) : count_q;

	// job report
	logic want_count, want_value, rep_load, rep_free;
	report_t rep;

	assign want_count = !mode_q && (count_nx != '0);
	assign want_value = mode_q && found_any_nx;
	assign rep_load = in_acc && in_jend && (want_count || want_value);

	always_comb begin
		rep.bank = bank_q;
		rep.len = len_nx;
		if (!mode_q) begin
			rep.kind = KIND_COUNT;
			rep.count = (count_nx > COUNT_LIMIT) ? COUNT_LIMIT : count_nx;
			rep.ovf = count_nx > COUNT_LIMIT;
			rep.trunc = 1'b0;
		end else begin
			rep.kind = (len_nx == '0) ? KIND_EMPTY : KIND_VALUE;
			rep.count = '0;
			rep.ovf = 1'b0;
			rep.trunc = trunc_nx;
		end
	end

	// a job-end byte waits only while the previous report still drains
	assign s_tready = !in_jend || rep_free;
	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q <= '0;
			stopped_q <= 1'b0;
			count_q <= '0;
			len_q <= '0;
			capture_q <= 1'b0;
			found_any_q <= 1'b0;
			found_main_q <= 1'b0;
			trunc_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (in_acc) begin
			if (seg_reset) begin
				holdoff_q <= '0;
				stopped_q <= 1'b0;
				capture_q <= 1'b0;
			end else begin
				stopped_q <= stop_nx;
				if (holdoff_q != 5'd0) begin
					holdoff_q <= holdoff_q - 5'd1;
				end else if (hit) begin
					holdoff_q <= 5'(n_eff - 6'd1);
				end
				if (accepted) begin
					capture_q <= 1'b1;
				end else if (capture_q && is_term) begin
					capture_q <= 1'b0;
				end
			end
			if (in_jend) begin
				count_q <= '0;
				len_q <= '0;
				found_any_q <= 1'b0;
				found_main_q <= 1'b0;
				trunc_q <= 1'b0;
				// hand the filled bank to the readout
				if (rep_load && (rep.kind == KIND_VALUE)) begin
					bank_q <= !bank_q;
				end
			end else begin
				count_q <= count_nx;
				len_q <= len_nx;
				found_any_q <= found_any_nx;
				found_main_q <= found_main_q || (accepted && !in_seg);
				trunc_q <= trunc_nx;
			end
		end
	end

	// value ram: two banks of captured bytes
	logic rd_en;
	logic [IDX_W:0] rd_addr;
	logic [7:0] rd_data;

	lpcc_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (in_acc && cap_store),
		.waddr ({bank_q, len_q[IDX_W-1:0]}),
		.wdata (in_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lpcc_readout #(
		.IDX_W (IDX_W)
	) u_readout (
		.clk      (clk),
		.arst_n   (arst_n),
		.rep_load (rep_load),
		.rep_in   (rep),
		.rep_free (rep_free),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ sv/lpcc_checker.sv @@
// ----------------------------------------------------------------------------
// lpcc_checker
// port-level checks on the result stream of the pattern scanner
// ----------------------------------------------------------------------------
module lpcc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lpcc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]                       m_tuser,
	input logic                             m_tlast
);
	import lpcc_pkg::*;

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("result changed while stalled");

	// count result: single, nonzero, saturated with overflow flag
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_COUNT) |-> m_tlast && (m_tdata[13:0] != '0) &&
			(m_tdata[13:0] <= COUNT_LIMIT) && (!m_tdata[14] || (m_tdata[13:0] == COUNT_LIMIT)) &&
			(m_tdata[23:15] == '0))
		else $error("bad count result");

	// empty value: single result, no count, no byte
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata[22:0] == '0))
		else $error("bad empty value result");

	// captured bytes never hold the line terminators
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_VALUE) |-> (m_tdata[14:0] == '0) &&
			(m_tdata[22:15] != CHAR_NUL) && (m_tdata[22:15] != CHAR_NEWLINE))
		else $error("bad value byte result");

endmodule

bind log_pattern_count_and_capture lpcc_checker u_lpcc_checker (.*);
